[src/ntpb_pkg.sv]
package ntpb_pkg;

   localparam int TIME_W = 63;
   localparam int POSE_W = 64;

   localparam logic [TIME_W-1:0] MAX_AGE_RESET = 63'd500000000;

   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic              func;
      logic [TIME_W-1:0] time_stamp;
      logic [TIME_W-1:0] current_time;
      logic [POSE_W-1:0] pose_value;
   } req_type;

   typedef struct packed {
      logic              is_identity;
      logic [POSE_W-1:0] pose_out;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_stamp;
      logic [POSE_W-1:0] pose;
   } entry_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_FWD,
      SHIFT_BACK
   } shift_type;

   typedef struct packed {
      shift_type shift;
      logic      we;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEEK,
      ST_PRUNE,
      ST_WRITE,
      ST_Q_START,
      ST_Q_STEP,
      ST_Q_TEST,
      ST_Q_PICK,
      ST_Q_DIFF,
      ST_Q_ABS,
      ST_Q_CMP,
      ST_OUT
   } state_type;

endpackage

[src/ntpb_cell.sv]
module ntpb_cell (
   input  logic                    clock,
   input  ntpb_pkg::cell_ctrl_type ctrl,
   input  ntpb_pkg::entry_type     wr_data,
   input  ntpb_pkg::entry_type     next_data,
   input  ntpb_pkg::entry_type     prev_data,
   output ntpb_pkg::entry_type     data
);

   ntpb_pkg::entry_type data_ff;
   ntpb_pkg::entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.we) begin
         data_in = wr_data;
      end else begin
         case (ctrl.shift)
            ntpb_pkg::SHIFT_FWD:  data_in = next_data;
            ntpb_pkg::SHIFT_BACK: data_in = prev_data;
            default:              data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[src/nearest_timestamp_pose_buffer_core.sv]
// A push seeks the ring to the oldest slot (at most DEPTH/2 slots away), pops each expired
// entry from cell 0, then writes; a query runs a binary search, seeking to each probe, then
// seeks to its pick; an empty query returns identity. One item at a time: busy stays high
// until it is done. The ring of cells rotates one slot per cycle and only cells 0 and 1 are
// read, so the rotation distance sets how long busy stays high.
// Reset (synchronous) empties the buffer and restores max_age; results are a one-cycle strobe.
module nearest_timestamp_pose_buffer_core #(
   parameter int DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ntpb_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output ntpb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [ntpb_pkg::TIME_W-1:0]         csr_write_data
);

   localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int HALF_DEPTH = DEPTH / 2;
   localparam int TIME_W     = ntpb_pkg::TIME_W;
   localparam int POSE_W     = ntpb_pkg::POSE_W;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(DEPTH - 1) : s - 1'b1;
   endfunction

   // ring slot of a logical position, counted from the oldest entry
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] oldest,
                                                 input logic [SLOT_W-1:0] pos);
      logic [SLOT_W:0] sum;
      sum = {1'b0, oldest} + {1'b0, pos};
      if (sum >= (SLOT_W+1)'(DEPTH)) begin
         sum = sum - (SLOT_W+1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   ntpb_pkg::state_type state_ff, state_in;
   ntpb_pkg::state_type ret_ff, ret_in;

   logic [SLOT_W-1:0] view_ff, view_in;     // ring slot currently held in cell 0
   logic [SLOT_W-1:0] tgt_ff, tgt_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  first_ff, first_in;
   logic [CNT_W-1:0]  span_ff, span_in;
   logic [CNT_W-1:0]  half_ff, half_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;

   logic [TIME_W-1:0] max_age_ff, max_age_in;
   logic [TIME_W-1:0] q_ff, q_in;
   logic [POSE_W-1:0] pose_ff, pose_in;
   logic [TIME_W-1:0] cutoff_ff, cutoff_in;
   logic              prune_en_ff, prune_en_in;
   logic [TIME_W:0]   diff_lo_ff, diff_lo_in;
   logic [TIME_W:0]   diff_hi_ff, diff_hi_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ntpb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   ntpb_pkg::shift_type shift_cmd;
   logic                write_active;
   logic [SLOT_W-1:0]   write_cell;
   ntpb_pkg::entry_type wr_entry;

   ntpb_pkg::entry_type     cell_data [DEPTH];
   ntpb_pkg::cell_ctrl_type cell_ctrl [DEPTH];

   logic              accept;
   logic [TIME_W:0]   cut_diff;
   logic [SLOT_W:0]   seek_diff;
   logic [SLOT_W:0]   seek_delta;
   logic              seek_done;
   logic              prune_hit;
   logic              test_lt;

   assign accept    = start && (state_ff == ntpb_pkg::ST_IDLE);
   assign busy      = (state_ff != ntpb_pkg::ST_IDLE);
   assign cut_diff  = {1'b0, req_data.current_time} - {1'b0, max_age_ff};
   assign seek_diff = {1'b0, tgt_ff} - {1'b0, view_ff};
   assign seek_delta = seek_diff[SLOT_W] ? seek_diff + (SLOT_W+1)'(DEPTH) : seek_diff;
   assign seek_done = (view_ff == tgt_ff);
   assign prune_hit = (count_ff != '0) && prune_en_ff &&
                      (cell_data[0].time_stamp < cutoff_ff);
   assign test_lt   = (cell_data[0].time_stamp < q_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntpb_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.func == ntpb_pkg::FUNC_PUSH) ? ntpb_pkg::ST_SEEK
                                                                 : ntpb_pkg::ST_Q_START;
            end
         end
         ntpb_pkg::ST_SEEK:    if (seek_done) state_in = ret_ff;
         ntpb_pkg::ST_PRUNE:   if (!prune_hit) state_in = ntpb_pkg::ST_WRITE;
         ntpb_pkg::ST_WRITE:   state_in = ntpb_pkg::ST_IDLE;
         ntpb_pkg::ST_Q_START: begin
            state_in = (count_ff == '0) ? ntpb_pkg::ST_IDLE : ntpb_pkg::ST_Q_STEP;
         end
         ntpb_pkg::ST_Q_STEP: begin
            state_in = (span_ff == '0) ? ntpb_pkg::ST_Q_PICK : ntpb_pkg::ST_SEEK;
         end
         ntpb_pkg::ST_Q_TEST:  state_in = ntpb_pkg::ST_Q_STEP;
         ntpb_pkg::ST_Q_PICK:  state_in = ntpb_pkg::ST_SEEK;
         ntpb_pkg::ST_Q_DIFF:  state_in = ntpb_pkg::ST_Q_ABS;
         ntpb_pkg::ST_Q_ABS:   state_in = ntpb_pkg::ST_Q_CMP;
         ntpb_pkg::ST_Q_CMP:   state_in = ntpb_pkg::ST_IDLE;
         ntpb_pkg::ST_OUT:     state_in = ntpb_pkg::ST_IDLE;
         default:              state_in = ntpb_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      ret_in       = ret_ff;
      view_in      = view_ff;
      tgt_in       = tgt_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      span_in      = span_ff;
      half_in      = half_ff;
      mid_in       = mid_ff;
      max_age_in   = max_age_ff;
      q_in         = q_ff;
      pose_in      = pose_ff;
      cutoff_in    = cutoff_ff;
      prune_en_in  = prune_en_ff;
      diff_lo_in   = diff_lo_ff;
      diff_hi_in   = diff_hi_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      shift_cmd    = ntpb_pkg::SHIFT_HOLD;
      write_active = 1'b0;
      write_cell   = '0;

      if (csr_write_en) begin
         max_age_in = csr_write_data;
      end

      unique case (state_ff)
         ntpb_pkg::ST_IDLE: begin
            if (accept) begin
               q_in        = req_data.time_stamp;
               pose_in     = req_data.pose_value;
               cutoff_in   = cut_diff[TIME_W-1:0];
               prune_en_in = !cut_diff[TIME_W];
               tgt_in      = oldest_ff;
               ret_in      = ntpb_pkg::ST_PRUNE;
            end
         end
         ntpb_pkg::ST_SEEK: begin
            if (!seek_done) begin
               if (seek_delta <= (SLOT_W+1)'(HALF_DEPTH)) begin
                  shift_cmd = ntpb_pkg::SHIFT_FWD;
                  view_in   = slot_inc(view_ff);
               end else begin
                  shift_cmd = ntpb_pkg::SHIFT_BACK;
                  view_in   = slot_dec(view_ff);
               end
            end
         end
         ntpb_pkg::ST_PRUNE: begin
            // cell 0 holds the oldest entry; popping rotates the ring along with it
            if (prune_hit) begin
               shift_cmd = ntpb_pkg::SHIFT_FWD;
               view_in   = slot_inc(view_ff);
               oldest_in = slot_inc(oldest_ff);
               count_in  = count_ff - 1'b1;
            end
         end
         ntpb_pkg::ST_WRITE: begin
            write_active = 1'b1;
            if (count_ff < CNT_W'(DEPTH)) begin
               write_cell = count_ff[SLOT_W-1:0];
               count_in   = count_ff + 1'b1;
            end else begin
               write_cell = '0;
               oldest_in  = slot_inc(oldest_ff);
            end
         end
         ntpb_pkg::ST_Q_START: begin
            first_in = '0;
            span_in  = count_ff;
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{is_identity: 1'b1, pose_out: '0};
            end
         end
         ntpb_pkg::ST_Q_STEP: begin
            half_in = span_ff >> 1;
            mid_in  = first_ff + (span_ff >> 1);
            tgt_in  = slot_of(oldest_ff, mid_in[SLOT_W-1:0]);
            ret_in  = ntpb_pkg::ST_Q_TEST;
         end
         ntpb_pkg::ST_Q_TEST: begin
            if (test_lt) begin
               first_in = mid_ff + 1'b1;
               span_in  = span_ff - half_ff - 1'b1;
            end else begin
               span_in  = half_ff;
            end
         end
         ntpb_pkg::ST_Q_PICK: begin
            if (first_ff >= count_ff) begin
               tgt_in = slot_of(oldest_ff, count_ff[SLOT_W-1:0] - 1'b1);
               ret_in = ntpb_pkg::ST_OUT;
            end else if (first_ff == '0) begin
               tgt_in = oldest_ff;
               ret_in = ntpb_pkg::ST_OUT;
            end else begin
               // earlier neighbor lands in cell 0, later one in cell 1
               tgt_in = slot_of(oldest_ff, first_ff[SLOT_W-1:0] - 1'b1);
               ret_in = ntpb_pkg::ST_Q_DIFF;
            end
         end
         ntpb_pkg::ST_Q_DIFF: begin
            diff_lo_in = {1'b0, cell_data[0].time_stamp} - {1'b0, q_ff};
            diff_hi_in = {1'b0, cell_data[1].time_stamp} - {1'b0, q_ff};
         end
         ntpb_pkg::ST_Q_ABS: begin
            if (diff_lo_ff[TIME_W]) diff_lo_in = '0 - diff_lo_ff;
            if (diff_hi_ff[TIME_W]) diff_hi_in = '0 - diff_hi_ff;
         end
         ntpb_pkg::ST_Q_CMP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.is_identity = 1'b0;
            rsp_data_in.pose_out    = (diff_hi_ff < diff_lo_ff) ? cell_data[1].pose
                                                                : cell_data[0].pose;
         end
         ntpb_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{is_identity: 1'b0, pose_out: cell_data[0].pose};
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   assign wr_entry = '{time_stamp: q_ff, pose: pose_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntpb_pkg::ST_IDLE;
         ret_ff       <= ntpb_pkg::ST_IDLE;
         view_ff      <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         max_age_ff   <= ntpb_pkg::MAX_AGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         view_ff      <= view_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         max_age_ff   <= max_age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      first_ff    <= first_in;
      span_ff     <= span_in;
      half_ff     <= half_in;
      mid_ff      <= mid_in;
      q_ff        <= q_in;
      pose_ff     <= pose_in;
      cutoff_ff   <= cutoff_in;
      prune_en_ff <= prune_en_in;
      diff_lo_ff  <= diff_lo_in;
      diff_hi_ff  <= diff_hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ring of cells: cell j holds ring slot view + j
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      assign cell_ctrl[j] = '{shift: shift_cmd,
                              we: write_active && (write_cell == SLOT_W'(j))};

      ntpb_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[j]),
         .wr_data   (wr_entry),
         .next_data (cell_data[(j + 1) % DEPTH]),
         .prev_data (cell_data[(j + DEPTH - 1) % DEPTH]),
         .data      (cell_data[j])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_oldest_range: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= SLOT_W'(DEPTH - 1))
      else $error("oldest slot out of range");

   a_view_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ntpb_pkg::ST_PRUNE || state_ff == ntpb_pkg::ST_WRITE) |->
         view_ff == oldest_ff)
      else $error("ring not aligned to oldest entry during push");

   a_push_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == ntpb_pkg::FUNC_PUSH) |=> !rsp_valid_ff)
      else $error("push produced a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

endmodule

[tb/pose_buffer_checker.sv]
module pose_buffer_checker #(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  ntpb_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  ntpb_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_en,
   input  logic [ntpb_pkg::TIME_W-1:0]  csr_write_data,
   output int                           fail_count,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_W = ntpb_pkg::TIME_W;
   localparam int POSE_W = ntpb_pkg::POSE_W;

   // mirror of the sample ring
   logic [TIME_W-1:0] ts_mem   [DEPTH];
   logic [POSE_W-1:0] pose_mem [DEPTH];
   int unsigned       head;
   int unsigned       fill;
   logic [TIME_W-1:0] window;

   ntpb_pkg::rsp_type expected_poses [$];
   int                errs;

   function automatic int unsigned ring_idx(input int unsigned pos);
      return (head + pos) % DEPTH;
   endfunction

   function automatic logic [TIME_W-1:0] abs_gap(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic store_sample(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] now,
                               input logic [POSE_W-1:0] pose);
      logic [TIME_W-1:0] cutoff;
      // window reaching before time zero prunes nothing
      if (now >= window) begin
         cutoff = now - window;
         while (fill > 0 && ts_mem[head] < cutoff) begin
            head = (head + 1) % DEPTH;
            fill--;
         end
      end
      if (fill < DEPTH) begin
         ts_mem[ring_idx(fill)]   = t;
         pose_mem[ring_idx(fill)] = pose;
         fill++;
      end else begin
         // full ring: overwrite the oldest
         ts_mem[head]   = t;
         pose_mem[head] = pose;
         head = (head + 1) % DEPTH;
      end
   endtask

   function automatic ntpb_pkg::rsp_type nearest_pose(input logic [TIME_W-1:0] q);
      ntpb_pkg::rsp_type r;
      int unsigned       first, span, half, mid, s_hi, s_lo;
      logic [TIME_W-1:0] d_hi, d_lo;
      r = '0;
      if (fill == 0) begin
         r.is_identity = 1'b1;
         return r;
      end
      first = 0;
      span  = fill;
      while (span > 0) begin
         half = span / 2;
         mid  = first + half;
         if (ts_mem[ring_idx(mid)] < q) begin
            first = mid + 1;
            span  = span - (half + 1);
         end else begin
            span = half;
         end
      end
      if (first >= fill) begin
         r.pose_out = pose_mem[ring_idx(fill - 1)];
      end else if (first == 0) begin
         r.pose_out = pose_mem[ring_idx(0)];
      end else begin
         s_hi = ring_idx(first);
         s_lo = ring_idx(first - 1);
         d_hi = abs_gap(ts_mem[s_hi], q);
         d_lo = abs_gap(ts_mem[s_lo], q);
         // tie goes to the earlier entry
         r.pose_out = (d_hi < d_lo) ? pose_mem[s_hi] : pose_mem[s_lo];
      end
      return r;
   endfunction

   task automatic flag_error(input string msg);
      errs++;
      if (errs <= 10) $display("%t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : watch
      ntpb_pkg::rsp_type want;
      if (reset) begin
         head   = 0;
         fill   = 0;
         window = ntpb_pkg::MAX_AGE_RESET;
         expected_poses.delete();
      end else begin
         // compare first: a new item may be taken at the edge that ends a result
         if (rsp_valid) begin
            if (expected_poses.size() == 0) begin
               flag_error($sformatf("unexpected result: identity %0b pose %h",
                                    rsp_data.is_identity, rsp_data.pose_out));
            end else begin
               want = expected_poses[0];
               expected_poses.delete(0);
               if (rsp_data.is_identity !== want.is_identity ||
                   rsp_data.pose_out !== want.pose_out)
                  flag_error($sformatf(
                     "result mismatch: identity exp %0b got %0b, pose exp %h got %h",
                     want.is_identity, rsp_data.is_identity, want.pose_out,
                     rsp_data.pose_out));
            end
         end
         if (csr_write_en) window = csr_write_data;
         if (start && !busy) begin
            if (req_data.func == ntpb_pkg::FUNC_QUERY)
               expected_poses.insert(expected_poses.size(),
                                     nearest_pose(req_data.time_stamp));
            else
               store_sample(req_data.time_stamp, req_data.current_time, req_data.pose_value);
         end
      end
      pending    <= expected_poses.size();
      fail_count <= errs;
   end

endmodule

[tb/nearest_timestamp_pose_buffer_core_tb.sv]
module nearest_timestamp_pose_buffer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_W = ntpb_pkg::TIME_W;
   localparam int POSE_W = ntpb_pkg::POSE_W;
   localparam int DEPTH  = 256;
   localparam int SETTLE = 2 * DEPTH + 100;
   localparam int LIMIT  = 6_000_000;
   localparam int PHASES = 5;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [POSE_W-1:0] POSE_MAX = {POSE_W{1'b1}};

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   ntpb_pkg::req_type req_data;
   logic              rsp_valid;
   ntpb_pkg::rsp_type rsp_data;
   logic              csr_write_en;
   logic [TIME_W-1:0] csr_write_data;
   int                fail_count;
   int                pending;
   int                cycle_cnt;

   // stimulus-side clock and recent sample times, used to aim queries
   logic [TIME_W-1:0] clk_ns;
   logic [TIME_W-1:0] pushed_ts [$];

   logic [TIME_W-1:0] age_list   [PHASES];
   int unsigned       step_list  [PHASES];
   int                idle_list  [PHASES];
   int                items_list [PHASES];
   int                push_list  [PHASES];

   nearest_timestamp_pose_buffer_core #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   pose_buffer_checker #(.DEPTH(DEPTH)) pose_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_cnt = 0;
      while (cycle_cnt < LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic ntpb_pkg::req_type mk(input logic f, input logic [TIME_W-1:0] t,
                                            input logic [TIME_W-1:0] now,
                                            input logic [POSE_W-1:0] p);
      ntpb_pkg::req_type r;
      r.func         = f;
      r.time_stamp   = t;
      r.current_time = now;
      r.pose_value   = p;
      return r;
   endfunction

   function automatic logic [POSE_W-1:0] rand_pose();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(input ntpb_pkg::req_type r);
      req_data <= r;
      if (!start) start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int idle_pct);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every expected result is back and the block is quiet
   task automatic drain();
      if (start) start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_max_age(input logic [TIME_W-1:0] v);
      csr_write_data <= v;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic random_item(input int push_pct, input int unsigned step_max,
                              output ntpb_pkg::req_type r);
      int                roll;
      int unsigned       lag, k;
      logic [TIME_W-1:0] a, b, q;
      roll = $urandom_range(99);
      if (roll < 4) begin
         // noise: every field fully random
         r = mk(1'(($urandom_range(1))), TIME_W'({$urandom, $urandom}),
                TIME_W'({$urandom, $urandom}), rand_pose());
      end else if (roll < push_pct) begin
         clk_ns = clk_ns + $urandom_range(step_max);
         if ($urandom_range(9) == 0) lag = $urandom_range(step_max * 4);
         else lag = $urandom_range(step_max / 8);
         a = (lag > clk_ns) ? '0 : clk_ns - lag;
         pushed_ts.insert(pushed_ts.size(), a);
         if (pushed_ts.size() > 300) pushed_ts.delete(0);
         r = mk(ntpb_pkg::FUNC_PUSH, a, clk_ns, rand_pose());
      end else begin
         if (pushed_ts.size() == 0) begin
            q = clk_ns + $urandom_range(step_max);
         end else begin
            k = $urandom_range(pushed_ts.size() - 1);
            a = pushed_ts[k];
            b = (k + 1 < pushed_ts.size()) ? pushed_ts[k + 1] : clk_ns;
            case ($urandom_range(5))
               0: q = a;
               1: q = a + $urandom_range(step_max);
               2: q = (a > step_max) ? a - $urandom_range(step_max) : '0;
               // midpoint of neighbors, often an exact tie
               3, 4: q = (a <= b) ? a + (b - a) / 2 : b + (a - b) / 2;
               default: q = ($urandom_range(1) == 0) ? '0 : clk_ns + $urandom_range(step_max);
            endcase
         end
         r = mk(ntpb_pkg::FUNC_QUERY, q, TIME_W'({$urandom, $urandom}), rand_pose());
      end
   endtask

   initial begin : stimulus
      ntpb_pkg::req_type r;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      clk_ns         = '0;

      age_list   = '{ntpb_pkg::MAX_AGE_RESET, TIME_MAX, '0,
                     TIME_W'(1000 + $urandom_range(1000)), TIME_W'($urandom)};
      step_list  = '{20_000_000, 1000, 100, 200, 50_000_000};
      idle_list  = '{0, 48, 20, 0, 48};
      items_list = '{300, 500, 250, 250, 300};
      push_list  = '{60, 80, 50, 60, 60};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_max_age(ntpb_pkg::MAX_AGE_RESET);

      // directed: empty, edges, ties, out-of-order, pruning
      send_item(mk(ntpb_pkg::FUNC_QUERY, '0, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, TIME_MAX, TIME_MAX, POSE_MAX));
      send_item(mk(ntpb_pkg::FUNC_PUSH, 63'd1000, 63'd1000, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, '0, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, TIME_MAX, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_PUSH, 63'd2000, 63'd2000, POSE_MAX));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd1500, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd1501, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd1000, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd2000, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_PUSH, 63'd1500, 63'd2100, rand_pose()));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd1700, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd1250, '0, '0));
      // cutoff exactly zero: nothing pruned
      send_item(mk(ntpb_pkg::FUNC_PUSH, 63'd3000, ntpb_pkg::MAX_AGE_RESET, rand_pose()));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd2900, '0, '0));
      // present at the top of the range prunes everything older
      send_item(mk(ntpb_pkg::FUNC_PUSH, TIME_MAX, TIME_MAX, rand_pose()));
      send_item(mk(ntpb_pkg::FUNC_QUERY, '0, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_PUSH, '0, '0, rand_pose()));
      send_item(mk(ntpb_pkg::FUNC_QUERY, TIME_MAX, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'h4000_0000_0000_0000, '0, '0));
      send_item(mk(ntpb_pkg::FUNC_PUSH, 63'd5, 63'd499999999, rand_pose()));
      send_item(mk(ntpb_pkg::FUNC_QUERY, 63'd3, '0, '0));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         clk_ns = (ph == 0) ? '0 : TIME_W'({$urandom, $urandom}) & 63'h3FFF_FFFF_FFFF_FFFF;
         pushed_ts.delete();
         write_max_age(age_list[ph]);
         for (int n = 0; n < items_list[ph]; n++) begin
            random_item(push_list[ph], step_list[ph], r);
            send_item(r);
            if (n == items_list[ph] / 2) drain();
            else hold_off(idle_list[ph]);
         end
         drain();
      end

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
